// ----- hw/rtl/brl_pkg.sv -----
// Byte-range lock table: shared types, codes and constants.
// No dependencies; every other file imports this package.
`default_nettype none

package brl_pkg;

    localparam int          BRL_SLOTS = 64;
    localparam logic [63:0] TOP_VAL   = '1;

    localparam logic [1:0] KIND_ACQ  = 2'd0;
    localparam logic [1:0] KIND_REL  = 2'd1;
    localparam logic [1:0] KIND_TEST = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ORIGIN   = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SORT,
        S_COMMIT,
        S_INSERT,
        S_EMIT_ONE,
        S_EMIT_LIST
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] node;
        logic [31:0] session;
        logic [63:0] owner;
        logic [63:0] lock_id;
        logic [63:0] offset;
        logic [63:0] length;
        logic [31:0] pid;
        logic        mode;
        logic        origin;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        removed_valid;
        logic [63:0] removed_lock;
        logic [63:0] conflict_owner;
        logic [63:0] conflict_offset;
        logic [63:0] conflict_length;
        logic [31:0] conflict_pid;
        logic        conflict_mode;
        logic        held_origin;
        logic        last;
    } t_res;

    // request and sequencing controls broadcast to every cell
    typedef struct packed {
        logic [63:0] node;
        logic [31:0] session;
        logic [63:0] owner;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        acq;
        logic        mode;
        logic [63:0] lock;
        logic [31:0] pid;
        logic        origin;
        logic [63:0] obj;
        logic [63:0] sp_low;
        logic [63:0] sp_lock;
        logic [31:0] sp_pid;
        logic        sp_mode;
        logic        sp_origin;
        logic [63:0] sp_obj;
        logic        split;
        logic        t_found;
        logic        commit;
        logic        ring_load;
        logic        ring_run;
        logic        sort_load;
        logic        sort_run;
        logic        sort_odd;
        logic        emit_shift;
    } t_bcast;

    // running scan result handed from cell to cell
    typedef struct packed {
        logic        held_found;
        logic        held_origin;
        logic        cnf_found;
        logic [63:0] cnf_owner;
        logic [63:0] cnf_low;
        logic [63:0] cnf_len;
        logic [31:0] cnf_pid;
        logic        cnf_mode;
        logic        ign;
        logic        f_found;
        logic [63:0] f_high;
        logic [63:0] f_low;
        logic [63:0] f_obj;
        logic [63:0] f_lock;
        logic [31:0] f_pid;
        logic        f_mode;
        logic        f_origin;
        logic        t_found;
        logic [63:0] t_high;
    } t_scan;

    // record that travels the row: ring compare, sort, then result queue
    typedef struct packed {
        logic [63:0] obj;
        logic [63:0] lock;
        logic [63:0] high;
        logic        live;
        logic        del;
        logic        rep;
    } t_trav;

    // insertion wave
    typedef struct packed {
        logic go;
        logic p_split;
        logic p_new;
    } t_ins;

endpackage

`default_nettype wire

// ----- hw/rtl/brl_req_if.sv -----
// Request channel: valid/ready handshake carrying one t_req item.
// Depends on brl_pkg.
`default_nettype none

interface brl_req_if import brl_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/brl_res_if.sv -----
// Result channel: valid/ready handshake carrying one t_res item.
// Depends on brl_pkg.
`default_nettype none

interface brl_res_if import brl_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/brl_cell.sv -----
// One lock-table slot with its stage of the scan chain, traveler register
// and insertion stage. Depends on brl_pkg.
`default_nettype none

module brl_cell import brl_pkg::*; #(
    parameter int SLOTS    = BRL_SLOTS,
    parameter int CELL_IDX = 0,
    localparam int IW = $clog2(SLOTS),
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_bcast        i_bc,
    input  logic [IW-1:0] i_f_idx,
    input  logic [IW-1:0] i_t_idx,
    input  t_scan         i_scan,
    input  logic [IW-1:0] i_scan_f_idx,
    input  logic [IW-1:0] i_scan_t_idx,
    input  logic [CW-1:0] i_scan_cnt,
    input  logic [CW-1:0] i_scan_ndel,
    output t_scan         o_scan,
    output logic [IW-1:0] o_scan_f_idx,
    output logic [IW-1:0] o_scan_t_idx,
    output logic [CW-1:0] o_scan_cnt,
    output logic [CW-1:0] o_scan_ndel,
    input  t_trav         i_left,
    input  logic [IW-1:0] i_left_idx,
    input  t_trav         i_right,
    input  logic [IW-1:0] i_right_idx,
    output t_trav         o_trav,
    output logic [IW-1:0] o_trav_idx,
    input  t_ins          i_ins,
    output t_ins          o_ins
);

    localparam logic [IW-1:0] MY_IDX    = IW'(CELL_IDX);
    localparam bit            HAS_LEFT  = (CELL_IDX > 0);
    localparam bit            HAS_RIGHT = (CELL_IDX < SLOTS - 1);
    localparam bit            ODD       = ((CELL_IDX % 2) == 1);

    logic          r_valid;
    logic [63:0]   r_node;
    logic [31:0]   r_session;
    logic [63:0]   r_owner;
    logic [63:0]   r_low;
    logic [63:0]   r_high;
    logic [63:0]   r_lock;
    logic [31:0]   r_pid;
    logic          r_mode;
    logic          r_origin;
    logic [63:0]   r_obj;

    t_scan         r_scan, n_scan;
    logic [IW-1:0] r_scan_f_idx, n_scan_f_idx;
    logic [IW-1:0] r_scan_t_idx, n_scan_t_idx;
    logic [CW-1:0] r_scan_cnt, r_scan_ndel;

    t_trav         r_trav;
    logic [IW-1:0] r_trav_idx;
    logic          r_keep, r_later;
    t_ins          r_ins;

    logic same_own, nodem, owned, del_l, conf, ign_l;
    logic is_f, is_t, f_upd, t_upd;
    logic [63:0] cur_low;
    logic take_split, take_new;
    logic right_first, left_pair_swap, pair_right;

    assign same_own = (r_session == i_bc.session) && (r_owner == i_bc.owner);
    assign nodem    = r_valid && (r_node == i_bc.node);
    assign owned    = nodem && same_own;
    assign del_l    = owned && (r_high > i_bc.lo) && (r_high <= i_bc.hi);
    assign conf     = nodem && !same_own && (r_high > i_bc.lo) && (r_low < i_bc.hi)
                      && (r_mode || i_bc.mode);
    assign ign_l    = i_bc.acq && (i_bc.lo == i_bc.hi) && owned && (r_high == i_bc.hi);

    always_comb begin
        n_scan       = i_scan;
        n_scan_f_idx = i_scan_f_idx;
        n_scan_t_idx = i_scan_t_idx;
        if (!i_scan.held_found && nodem) begin
            n_scan.held_found  = 1'b1;
            n_scan.held_origin = r_origin;
        end
        if (!i_scan.cnf_found && conf) begin
            n_scan.cnf_found = 1'b1;
            n_scan.cnf_owner = r_owner;
            n_scan.cnf_low   = r_low;
            n_scan.cnf_len   = r_high - r_low;
            n_scan.cnf_pid   = r_pid;
            n_scan.cnf_mode  = r_mode;
        end
        if (ign_l) begin
            n_scan.ign = 1'b1;
        end
        if (owned && (r_high > i_bc.lo) && (!i_scan.f_found || r_high < i_scan.f_high)) begin
            n_scan.f_found  = 1'b1;
            n_scan.f_high   = r_high;
            n_scan.f_low    = r_low;
            n_scan.f_obj    = r_obj;
            n_scan.f_lock   = r_lock;
            n_scan.f_pid    = r_pid;
            n_scan.f_mode   = r_mode;
            n_scan.f_origin = r_origin;
            n_scan_f_idx    = MY_IDX;
        end
        if (owned && (r_high > i_bc.hi) && (!i_scan.t_found || r_high < i_scan.t_high)) begin
            n_scan.t_found = 1'b1;
            n_scan.t_high  = r_high;
            n_scan_t_idx   = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_scan_f_idx <= n_scan_f_idx;
        r_scan_t_idx <= n_scan_t_idx;
        r_scan_cnt   <= i_scan_cnt + CW'(r_valid);
        r_scan_ndel  <= i_scan_ndel + CW'(del_l);
    end

    assign o_scan       = r_scan;
    assign o_scan_f_idx = r_scan_f_idx;
    assign o_scan_t_idx = r_scan_t_idx;
    assign o_scan_cnt   = r_scan_cnt;
    assign o_scan_ndel  = r_scan_ndel;

    // odd-even transposition: reporters first, by ascending high, then index
    assign pair_right  = (ODD == i_bc.sort_odd);
    assign right_first = i_right.rep && (!r_trav.rep || (i_right.high < r_trav.high)
                         || ((i_right.high == r_trav.high) && (i_right_idx < r_trav_idx)));
    assign left_pair_swap = r_trav.rep && (!i_left.rep || (r_trav.high < i_left.high)
                         || ((r_trav.high == i_left.high) && (r_trav_idx < i_left_idx)));

    always_ff @(posedge i_clk) begin
        if (i_bc.ring_load) begin
            r_trav.obj  <= r_obj;
            r_trav.lock <= r_lock;
            r_trav.high <= r_high;
            r_trav.live <= r_valid && !del_l;
            r_trav.del  <= del_l;
            r_trav.rep  <= 1'b0;
            r_trav_idx  <= MY_IDX;
        end else if (i_bc.sort_load) begin
            r_trav.obj  <= r_obj;
            r_trav.lock <= r_lock;
            r_trav.high <= r_high;
            r_trav.live <= r_valid && !del_l;
            r_trav.del  <= del_l;
            r_trav.rep  <= del_l && !r_keep && !r_later
                           && !(i_bc.split && (r_obj == i_bc.sp_obj));
            r_trav_idx  <= MY_IDX;
        end else if (i_bc.ring_run) begin
            r_trav     <= i_left;
            r_trav_idx <= i_left_idx;
        end else if (i_bc.sort_run) begin
            if (pair_right) begin
                if (HAS_RIGHT && right_first) begin
                    r_trav     <= i_right;
                    r_trav_idx <= i_right_idx;
                end
            end else begin
                if (HAS_LEFT && left_pair_swap) begin
                    r_trav     <= i_left;
                    r_trav_idx <= i_left_idx;
                end
            end
        end else if (i_bc.emit_shift) begin
            r_trav     <= i_right;
            r_trav_idx <= i_right_idx;
        end
    end

    // ring pass: does any other fragment of my lock outlive me
    always_ff @(posedge i_clk) begin
        if (i_bc.ring_load) begin
            r_keep  <= 1'b0;
            r_later <= 1'b0;
        end else if (i_bc.ring_run && (r_trav.obj == r_obj)) begin
            if (r_trav.live) begin
                r_keep <= 1'b1;
            end
            if (r_trav.del && ((r_trav.high > r_high)
                    || ((r_trav.high == r_high) && (r_trav_idx > MY_IDX)))) begin
                r_later <= 1'b1;
            end
        end
    end

    assign o_trav     = r_trav;
    assign o_trav_idx = r_trav_idx;

    // commit and insertion
    assign is_f       = (i_f_idx == MY_IDX);
    assign is_t       = (i_t_idx == MY_IDX);
    assign f_upd      = is_f && i_bc.split && !del_l;
    assign cur_low    = f_upd ? i_bc.lo : r_low;
    assign t_upd      = is_t && i_bc.t_found && (cur_low < i_bc.hi);
    assign take_split = i_ins.go && !r_valid && i_ins.p_split;
    assign take_new   = i_ins.go && !r_valid && !i_ins.p_split && i_ins.p_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ins   <= '0;
        end else begin
            if (i_bc.commit && del_l) begin
                r_valid <= 1'b0;
            end else if (take_split || take_new) begin
                r_valid <= 1'b1;
            end
            r_ins.go      <= i_ins.go;
            r_ins.p_split <= i_ins.p_split && !take_split;
            r_ins.p_new   <= i_ins.p_new && !take_new;
        end
    end

    assign o_ins = r_ins;

    always_ff @(posedge i_clk) begin
        if (i_bc.commit) begin
            if (f_upd) begin
                r_low <= i_bc.lo;
            end
            if (t_upd) begin
                r_low <= i_bc.hi;
            end
        end else if (take_split) begin
            r_node    <= i_bc.node;
            r_session <= i_bc.session;
            r_owner   <= i_bc.owner;
            r_low     <= i_bc.sp_low;
            r_high    <= i_bc.lo;
            r_lock    <= i_bc.sp_lock;
            r_pid     <= i_bc.sp_pid;
            r_mode    <= i_bc.sp_mode;
            r_origin  <= i_bc.sp_origin;
            r_obj     <= i_bc.sp_obj;
        end else if (take_new) begin
            r_node    <= i_bc.node;
            r_session <= i_bc.session;
            r_owner   <= i_bc.owner;
            r_low     <= i_bc.lo;
            r_high    <= i_bc.hi;
            r_lock    <= i_bc.lock;
            r_pid     <= i_bc.pid;
            r_mode    <= i_bc.mode;
            r_origin  <= i_bc.origin;
            r_obj     <= i_bc.obj;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/brl_ctrl.sv -----
// Sequencer for the lock table: request decode, scan/sort/insert phases,
// decision and result delivery. Depends on brl_pkg.
`default_nettype none

module brl_ctrl import brl_pkg::*; #(
    parameter int SLOTS = BRL_SLOTS,
    localparam int IW = $clog2(SLOTS),
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  t_req          i_req_data,
    output logic          o_req_ready,
    output logic          o_res_valid,
    output t_res          o_res_data,
    input  logic          i_res_ready,
    output t_bcast        o_bc,
    output logic [IW-1:0] o_f_idx,
    output logic [IW-1:0] o_t_idx,
    output t_ins          o_ins,
    input  t_scan         i_scan,
    input  logic [IW-1:0] i_scan_f_idx,
    input  logic [IW-1:0] i_scan_t_idx,
    input  logic [CW-1:0] i_scan_cnt,
    input  logic [CW-1:0] i_scan_ndel,
    input  t_trav         i_head,
    input  logic          i_next_rep
);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt;
    t_req          r_req;
    logic [63:0]   r_lo, r_hi;
    t_res          r_res, n_res;
    logic          r_split, r_t_found;
    logic [63:0]   r_sp_low, r_sp_lock, r_sp_obj;
    logic [31:0]   r_sp_pid;
    logic          r_sp_mode, r_sp_origin;
    logic [IW-1:0] r_f_idx, r_t_idx;
    logic [63:0]   r_obj;

    logic          in_fire, out_fire, acq, split_n, full, to_sort, cnt_clr;
    logic [63:0]   len0;
    logic [CW:0]   need, room;

    assign in_fire  = i_req_valid && o_req_ready;
    assign out_fire = o_res_valid && i_res_ready;
    assign acq      = (r_req.kind == KIND_ACQ);
    assign len0     = (i_req_data.length == 64'd0) ? TOP_VAL : i_req_data.length;
    assign split_n  = i_scan.f_found && (i_scan.f_low < r_lo);
    assign need     = (CW+1)'(i_scan_cnt) + (CW+1)'(split_n) + (CW+1)'(acq);
    assign room     = (CW+1)'(SLOTS) + (CW+1)'(i_scan_ndel);
    assign full     = (need > room);

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        to_sort = 1'b0;
        cnt_clr = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res      = '0;
                    n_res.last = 1'b1;
                    cnt_clr    = 1'b1;
                    n_state    = (i_req_data.kind == KIND_NONE) ? S_EMIT_ONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == CW'(SLOTS)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_EMIT_ONE;
                if (i_scan.held_found && (i_scan.held_origin != r_req.origin)) begin
                    n_res.status      = ST_ORIGIN;
                    n_res.held_origin = i_scan.held_origin;
                end else if (r_req.kind == KIND_TEST) begin
                    if (i_scan.cnf_found) begin
                        n_res.status          = ST_CONFLICT;
                        n_res.conflict_owner  = i_scan.cnf_owner;
                        n_res.conflict_offset = i_scan.cnf_low;
                        n_res.conflict_length = i_scan.cnf_len;
                        n_res.conflict_pid    = i_scan.cnf_pid;
                        n_res.conflict_mode   = i_scan.cnf_mode;
                        n_res.held_origin     = i_scan.held_origin;
                    end
                end else if ((r_req.kind == KIND_REL) && !i_scan.held_found) begin
                    n_state = S_EMIT_ONE;
                end else if (acq && i_scan.ign) begin
                    n_state = S_EMIT_ONE;
                end else if (full) begin
                    n_res.status = ST_FULL;
                end else begin
                    to_sort = 1'b1;
                    cnt_clr = 1'b1;
                    n_state = S_SORT;
                end
            end
            S_SORT: begin
                if (r_cnt == CW'(SLOTS)) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cnt_clr = 1'b1;
                n_state = S_INSERT;
            end
            S_INSERT: begin
                if (r_cnt == CW'(SLOTS - 1)) begin
                    n_state = i_head.rep ? S_EMIT_LIST : S_EMIT_ONE;
                end
            end
            S_EMIT_ONE: begin
                if (out_fire) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_LIST: begin
                if (out_fire && !i_next_rep) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_obj   <= '0;
        end else begin
            r_state <= n_state;
            if (cnt_clr) begin
                r_cnt <= '0;
            end else if (r_cnt != CW'(SLOTS)) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if ((r_state == S_COMMIT) && acq) begin
                r_obj <= r_obj + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (in_fire) begin
            r_req <= i_req_data;
            r_lo  <= i_req_data.offset;
            r_hi  <= (i_req_data.offset < (TOP_VAL - len0)) ? (i_req_data.offset + len0)
                                                           : TOP_VAL;
        end
        if (to_sort) begin
            r_split     <= split_n;
            r_t_found   <= i_scan.t_found;
            r_sp_low    <= i_scan.f_low;
            r_sp_lock   <= i_scan.f_lock;
            r_sp_obj    <= i_scan.f_obj;
            r_sp_pid    <= i_scan.f_pid;
            r_sp_mode   <= i_scan.f_mode;
            r_sp_origin <= i_scan.f_origin;
            r_f_idx     <= i_scan_f_idx;
            r_t_idx     <= i_scan_t_idx;
        end
    end

    always_comb begin
        o_bc            = '0;
        o_bc.node       = r_req.node;
        o_bc.session    = r_req.session;
        o_bc.owner      = r_req.owner;
        o_bc.lo         = r_lo;
        o_bc.hi         = r_hi;
        o_bc.acq        = acq;
        o_bc.mode       = r_req.mode;
        o_bc.lock       = r_req.lock_id;
        o_bc.pid        = r_req.pid;
        o_bc.origin     = r_req.origin;
        o_bc.obj        = r_obj;
        o_bc.sp_low     = r_sp_low;
        o_bc.sp_lock    = r_sp_lock;
        o_bc.sp_pid     = r_sp_pid;
        o_bc.sp_mode    = r_sp_mode;
        o_bc.sp_origin  = r_sp_origin;
        o_bc.sp_obj     = r_sp_obj;
        o_bc.split      = r_split;
        o_bc.t_found    = r_t_found;
        o_bc.commit     = (r_state == S_COMMIT);
        o_bc.ring_load  = (r_state == S_SCAN) && (r_cnt == '0);
        o_bc.ring_run   = (r_state == S_SCAN) && (r_cnt != '0);
        o_bc.sort_load  = (r_state == S_SORT) && (r_cnt == '0);
        o_bc.sort_run   = (r_state == S_SORT) && (r_cnt != '0);
        o_bc.sort_odd   = r_cnt[0];
        o_bc.emit_shift = (r_state == S_EMIT_LIST) && out_fire;
    end

    assign o_f_idx     = r_f_idx;
    assign o_t_idx     = r_t_idx;
    assign o_ins.go      = (r_state == S_INSERT) && (r_cnt == '0);
    assign o_ins.p_split = r_split;
    assign o_ins.p_new   = acq;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT_ONE) || (r_state == S_EMIT_LIST);

    always_comb begin
        if (r_state == S_EMIT_LIST) begin
            o_res_data               = '0;
            o_res_data.status        = ST_OK;
            o_res_data.removed_valid = 1'b1;
            o_res_data.removed_lock  = i_head.lock;
            o_res_data.last          = !i_next_rep;
        end else begin
            o_res_data = r_res;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/byte_range_lock_table.sv -----
// Byte-range lock table top level: sequencer plus a row of slot cells.
// Depends on brl_pkg, brl_req_if, brl_res_if, brl_cell, brl_ctrl.
//
// Holds SLOTS lock fragments, one per cell, and serves one request at a
// time. Each request walks a wave down the row of cells, one cell per clock:
// a test, an origin error, a full table or a release on an unlocked node
// needs only the scan walk; kind 3 skips the row. An acquire or release that
// edits the table takes three walks of the row (scan with ring compare,
// odd-even sort of the vanished locks, insertion of new fragments), then
// delivers its results. The table starts empty after reset and needs no
// clearing pass.
`default_nettype none

module byte_range_lock_table import brl_pkg::*; #(
    parameter int SLOTS = BRL_SLOTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brl_req_if.sink   i_req,
    brl_res_if.source o_res
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    t_bcast        w_bc;
    logic [IW-1:0] w_f_idx, w_t_idx;
    t_ins          w_ins0;

    t_scan         w_scan      [SLOTS];
    logic [IW-1:0] w_scan_f    [SLOTS];
    logic [IW-1:0] w_scan_t    [SLOTS];
    logic [CW-1:0] w_scan_cnt  [SLOTS];
    logic [CW-1:0] w_scan_ndel [SLOTS];
    t_trav         w_trav      [SLOTS];
    logic [IW-1:0] w_trav_idx  [SLOTS];
    t_ins          w_ins       [SLOTS];

    brl_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_data   (i_req.data),
        .o_req_ready  (i_req.ready),
        .o_res_valid  (o_res.valid),
        .o_res_data   (o_res.data),
        .i_res_ready  (o_res.ready),
        .o_bc         (w_bc),
        .o_f_idx      (w_f_idx),
        .o_t_idx      (w_t_idx),
        .o_ins        (w_ins0),
        .i_scan       (w_scan[SLOTS-1]),
        .i_scan_f_idx (w_scan_f[SLOTS-1]),
        .i_scan_t_idx (w_scan_t[SLOTS-1]),
        .i_scan_cnt   (w_scan_cnt[SLOTS-1]),
        .i_scan_ndel  (w_scan_ndel[SLOTS-1]),
        .i_head       (w_trav[0]),
        .i_next_rep   (w_trav[1].rep)
    );

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        t_scan         l_scan_in;
        logic [IW-1:0] l_f_in, l_t_in, l_left_idx, l_right_idx;
        logic [CW-1:0] l_cnt_in, l_ndel_in;
        t_trav         l_left, l_right;
        t_ins          l_ins_in;

        if (g == 0) begin : g_first
            assign l_scan_in  = '0;
            assign l_f_in     = '0;
            assign l_t_in     = '0;
            assign l_cnt_in   = '0;
            assign l_ndel_in  = '0;
            assign l_ins_in   = w_ins0;
            assign l_left     = w_trav[SLOTS-1];
            assign l_left_idx = w_trav_idx[SLOTS-1];
        end else begin : g_mid
            assign l_scan_in  = w_scan[g-1];
            assign l_f_in     = w_scan_f[g-1];
            assign l_t_in     = w_scan_t[g-1];
            assign l_cnt_in   = w_scan_cnt[g-1];
            assign l_ndel_in  = w_scan_ndel[g-1];
            assign l_ins_in   = w_ins[g-1];
            assign l_left     = w_trav[g-1];
            assign l_left_idx = w_trav_idx[g-1];
        end

        if (g == SLOTS - 1) begin : g_last
            assign l_right     = '0;
            assign l_right_idx = '0;
        end else begin : g_inner
            assign l_right     = w_trav[g+1];
            assign l_right_idx = w_trav_idx[g+1];
        end

        brl_cell #(.SLOTS(SLOTS), .CELL_IDX(g)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_bc         (w_bc),
            .i_f_idx      (w_f_idx),
            .i_t_idx      (w_t_idx),
            .i_scan       (l_scan_in),
            .i_scan_f_idx (l_f_in),
            .i_scan_t_idx (l_t_in),
            .i_scan_cnt   (l_cnt_in),
            .i_scan_ndel  (l_ndel_in),
            .o_scan       (w_scan[g]),
            .o_scan_f_idx (w_scan_f[g]),
            .o_scan_t_idx (w_scan_t[g]),
            .o_scan_cnt   (w_scan_cnt[g]),
            .o_scan_ndel  (w_scan_ndel[g]),
            .i_left       (l_left),
            .i_left_idx   (l_left_idx),
            .i_right      (l_right),
            .i_right_idx  (l_right_idx),
            .o_trav       (w_trav[g]),
            .o_trav_idx   (w_trav_idx[g]),
            .i_ins        (l_ins_in),
            .o_ins        (w_ins[g])
        );
    end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for byte_range_lock_table: directed table plus random lock traffic.
// Depends on brl_pkg, brl_req_if, brl_res_if and the RTL top level.
`timescale 1ns / 100ps

module tb;
    import brl_pkg::*;

    localparam int NS = BRL_SLOTS;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    brl_req_if req_if ();
    brl_res_if res_if ();

    byte_range_lock_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the fragment table
    bit          fr_valid [NS];
    logic [63:0] fr_node  [NS];
    logic [31:0] fr_sess  [NS];
    logic [63:0] fr_owner [NS];
    logic [63:0] fr_low   [NS];
    logic [63:0] fr_high  [NS];
    logic [63:0] fr_lock  [NS];
    logic [31:0] fr_pid   [NS];
    logic        fr_mode  [NS];
    logic        fr_orig  [NS];
    logic [63:0] fr_obj   [NS];
    logic [63:0] obj_count;

    t_res pending_res [$];
    int   err_count;
    bit   send_done;
    bit   hold_res;

    function automatic t_res blank_res(logic [1:0] st);
        t_res r;
        r = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < NS; i++)
            if (!fr_valid[i]) return i;
        return -1;
    endfunction

    task automatic punch_range(t_req q, logic [63:0] lo, logic [63:0] hi, bit acq,
                               ref t_res outs[$]);
        bit del [NS];
        bit done [NS];
        int f, t, cnt, ndel, split, d, j;
        logic [63:0] f_low, f_obj;
        bit alive;
        t_res r;
        f = -1; t = -1; cnt = 0; ndel = 0; split = 0;
        f_low = '0; f_obj = '0;
        for (int i = 0; i < NS; i++) begin
            del[i] = 0; done[i] = 0;
            if (fr_valid[i]) cnt++;
            if (!(fr_valid[i] && fr_node[i] == q.node && fr_sess[i] == q.session &&
                  fr_owner[i] == q.owner)) continue;
            if (acq && lo == hi && fr_high[i] == hi) begin
                outs = {outs, blank_res(ST_OK)};
                return;
            end
            if (fr_high[i] > lo && (f < 0 || fr_high[i] < fr_high[f])) f = i;
            if (fr_high[i] > hi && (t < 0 || fr_high[i] < fr_high[t])) t = i;
            if (fr_high[i] > lo && fr_high[i] <= hi) begin
                del[i] = 1; ndel++;
            end
        end
        if (f >= 0 && fr_low[f] < lo) begin
            split = 1; f_low = fr_low[f]; f_obj = fr_obj[f];
        end
        if (cnt - ndel + split + (acq ? 1 : 0) > NS) begin
            outs = {outs, blank_res(ST_FULL)};
            return;
        end
        forever begin
            d = -1;
            for (int i = 0; i < NS; i++)
                if (del[i] && !done[i] && (d < 0 || fr_high[i] < fr_high[d])) d = i;
            if (d < 0) break;
            done[d] = 1;
            alive = split && f_obj == fr_obj[d];
            for (j = 0; j < NS && !alive; j++) begin
                if (!fr_valid[j] || fr_obj[j] != fr_obj[d]) continue;
                if (!del[j] || !done[j]) alive = 1;
            end
            if (!alive) begin
                r = '0;
                r.removed_valid = 1'b1;
                r.removed_lock  = fr_lock[d];
                outs = {outs, r};
            end
        end
        for (int i = 0; i < NS; i++)
            if (del[i]) fr_valid[i] = 0;
        if (split) begin
            j = lowest_free();
            if (j >= 0) begin
                fr_valid[j] = 1;
                fr_node[j] = fr_node[f]; fr_sess[j] = fr_sess[f];
                fr_owner[j] = fr_owner[f]; fr_lock[j] = fr_lock[f];
                fr_pid[j] = fr_pid[f]; fr_mode[j] = fr_mode[f];
                fr_orig[j] = fr_orig[f]; fr_obj[j] = f_obj;
                fr_low[j] = f_low; fr_high[j] = lo;
            end
            if (!del[f]) fr_low[f] = lo;
        end
        if (t >= 0 && fr_valid[t] && fr_low[t] < hi) fr_low[t] = hi;
        if (acq) begin
            j = lowest_free();
            if (j >= 0) begin
                fr_valid[j] = 1;
                fr_node[j] = q.node; fr_sess[j] = q.session; fr_owner[j] = q.owner;
                fr_lock[j] = q.lock_id; fr_pid[j] = q.pid; fr_mode[j] = q.mode;
                fr_orig[j] = q.origin; fr_obj[j] = obj_count;
                obj_count++;
                fr_low[j] = lo; fr_high[j] = hi;
            end
        end
        if (outs.size() == 0) outs = {outs, blank_res(ST_OK)};
        else outs[outs.size()-1].last = 1'b1;
    endtask

    task automatic predict_lock(t_req q, ref t_res outs[$]);
        logic [63:0] len, lo, hi;
        bit locked;
        logic held;
        t_res r;
        outs = {};
        len = (q.length == 64'd0) ? TOP_VAL : q.length;
        lo = q.offset;
        hi = (q.offset < TOP_VAL - len) ? q.offset + len : TOP_VAL;
        if (q.kind == KIND_NONE) begin
            outs = {outs, blank_res(ST_OK)};
            return;
        end
        locked = 0; held = 1'b0;
        for (int i = 0; i < NS; i++)
            if (fr_valid[i] && fr_node[i] == q.node) begin
                locked = 1; held = fr_orig[i]; break;
            end
        if (locked && held != q.origin) begin
            r = blank_res(ST_ORIGIN);
            r.held_origin = held;
            outs = {outs, r};
            return;
        end
        if (q.kind == KIND_ACQ) begin
            punch_range(q, lo, hi, 1'b1, outs);
            return;
        end
        if (q.kind == KIND_REL) begin
            if (!locked) outs = {outs, blank_res(ST_OK)};
            else punch_range(q, lo, hi, 1'b0, outs);
            return;
        end
        for (int i = 0; i < NS; i++) begin
            if (!fr_valid[i] || fr_node[i] != q.node) continue;
            if (fr_sess[i] == q.session && fr_owner[i] == q.owner) continue;
            if (fr_high[i] <= lo || fr_low[i] >= hi) continue;
            if (fr_mode[i] == 1'b0 && q.mode == 1'b0) continue;
            r = blank_res(ST_CONFLICT);
            r.conflict_owner  = fr_owner[i];
            r.conflict_offset = fr_low[i];
            r.conflict_length = fr_high[i] - fr_low[i];
            r.conflict_pid    = fr_pid[i];
            r.conflict_mode   = fr_mode[i];
            r.held_origin     = held;
            outs = {outs, r};
            return;
        end
        outs = {outs, blank_res(ST_OK)};
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %0h expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // directed rows; a row with a typed result checks it against the predictor too
    typedef struct {
        t_req q;
        bit   typed;
        t_res want;
    } t_row;
    t_row rows [$];

    function automatic t_req mk(logic [1:0] k, logic [63:0] nd, logic [63:0] ow,
                                logic [63:0] off, logic [63:0] len, logic m, logic o);
        t_req q;
        q = '0;
        q.kind = k; q.node = nd; q.session = 32'h11; q.owner = ow;
        q.lock_id = {32'hABCD, off[31:0]}; q.offset = off; q.length = len;
        q.pid = 32'h55; q.mode = m; q.origin = o;
        return q;
    endfunction

    task automatic add_row(t_req q, bit typed, logic [1:0] st, logic ho);
        t_row r;
        r.q = q; r.typed = typed;
        r.want = blank_res(st);
        r.want.held_origin = ho;
        rows = {rows, r};
    endtask

    task automatic send_item(t_req q);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= q;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    logic [63:0] pool_node [4];
    logic [63:0] pool_owner [3];

    function automatic t_req rand_req();
        t_req q;
        q.kind = ($urandom_range(0, 19) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
        q.node = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                             : pool_node[$urandom_range(0, 3)];
        q.session = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(1, 2));
        q.owner = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                              : pool_owner[$urandom_range(0, 2)];
        q.lock_id = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: q.offset = {$urandom, $urandom};
            1: q.offset = TOP_VAL - 64'($urandom_range(0, 4));
            default: q.offset = 64'($urandom_range(0, 200));
        endcase
        case ($urandom_range(0, 5))
            0: q.length = '0;
            1: q.length = {$urandom, $urandom};
            default: q.length = 64'($urandom_range(1, 60));
        endcase
        q.pid = $urandom;
        q.mode = 1'($urandom_range(0, 1));
        q.origin = ($urandom_range(0, 7) == 0) ? 1'b1 : 1'b0;
        return q;
    endfunction

    initial begin
        t_res outs [$];
        t_req q;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        err_count = 0;
        send_done = 0;
        obj_count = '0;
        for (int i = 0; i < NS; i++) fr_valid[i] = 0;
        pool_node[0] = 64'h10; pool_node[1] = TOP_VAL; pool_node[2] = '0;
        pool_node[3] = 64'h8000_0000_0000_0001;
        pool_owner[0] = 64'h1; pool_owner[1] = 64'h2; pool_owner[2] = TOP_VAL;

        add_row(mk(KIND_TEST, 64'h10, 64'd1, 64'd0, 64'd0, 1'b1, 1'b0), 1'b1, ST_OK, 1'b0);
        add_row(mk(KIND_REL, 64'h10, 64'd1, 64'd0, 64'd0, 1'b0, 1'b0), 1'b1, ST_OK, 1'b0);
        add_row(mk(KIND_NONE, 64'h10, 64'd1, 64'd0, 64'd0, 1'b0, 1'b0), 1'b1, ST_OK, 1'b0);
        add_row(mk(KIND_ACQ, 64'h10, 64'd1, 64'd0, 64'd0, 1'b1, 1'b0), 1'b0, ST_OK, 1'b0);
        add_row(mk(KIND_ACQ, 64'h10, 64'd1, TOP_VAL, 64'd5, 1'b1, 1'b0),
                1'b0, ST_OK, 1'b0);
        add_row(mk(KIND_TEST, 64'h10, 64'd2, 64'd100, 64'd10, 1'b0, 1'b1),
                1'b1, ST_ORIGIN, 1'b0);
        add_row(mk(KIND_ACQ, 64'h10, 64'd2, 64'd100, 64'd10, 1'b0, 1'b1),
                1'b1, ST_ORIGIN, 1'b0);
        add_row(mk(KIND_TEST, 64'h10, 64'd2, 64'd100, 64'd10, 1'b0, 1'b0),
                1'b0, ST_OK, 1'b0);
        add_row(mk(KIND_ACQ, 64'h10, 64'd1, 64'd50, 64'd20, 1'b0, 1'b0),
                1'b0, ST_OK, 1'b0);
        add_row(mk(KIND_REL, 64'h10, 64'd1, 64'd55, 64'd5, 1'b0, 1'b0),
                1'b0, ST_OK, 1'b0);
        add_row(mk(KIND_TEST, 64'h10, 64'd2, 64'd40, 64'd30, 1'b0, 1'b0),
                1'b0, ST_OK, 1'b0);
        add_row(mk(KIND_ACQ, TOP_VAL, TOP_VAL, TOP_VAL - 64'd3, TOP_VAL, 1'b0, 1'b1),
                1'b0, ST_OK, 1'b0);
        add_row(mk(KIND_TEST, TOP_VAL, 64'd3, TOP_VAL - 64'd1, 64'd1, 1'b1, 1'b1),
                1'b0, ST_OK, 1'b0);
        add_row(mk(KIND_REL, 64'h10, 64'd1, 64'd0, 64'd0, 1'b0, 1'b0), 1'b0, ST_OK, 1'b0);
        add_row(mk(KIND_REL, TOP_VAL, TOP_VAL, 64'd0, 64'd0, 1'b0, 1'b1),
                1'b0, ST_OK, 1'b0);
        // fill the table to reach the full status
        for (int i = 0; i < NS + 1; i++)
            add_row(mk(KIND_ACQ, 64'h20, 64'd7, 64'(i * 4), 64'd2, 1'b0, 1'b0),
                    i == NS, ST_FULL, 1'b0);
        add_row(mk(KIND_ACQ, 64'h20, 64'd7, 64'd1, 64'd2, 1'b0, 1'b0),
                1'b1, ST_FULL, 1'b0);
        add_row(mk(KIND_REL, 64'h20, 64'd7, 64'd0, 64'd0, 1'b0, 1'b0),
                1'b0, ST_OK, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            q = rows[k].q;
            predict_lock(q, outs);
            if (rows[k].typed && outs[0] != rows[k].want)
                report_mismatch("directed status", 64'(outs[0].status),
                                64'(rows[k].want.status));
            pending_res = {pending_res, outs};
            send_item(q);
        end
        for (int n = 0; n < 400; n++) begin
            q = rand_req();
            predict_lock(q, outs);
            pending_res = {pending_res, outs};
            send_item(q);
        end
        req_if.valid <= 1'b0;
        send_done = 1;
    end

    initial begin
        res_if.ready = 1'b0;
        hold_res = 0;
        @(posedge i_rst_n);
        forever begin
            int gap;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            if (hold_res) begin
                hold_res = 0;
                res_if.ready <= 1'b0;
                repeat (2000) @(posedge i_clk);
            end else if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    // one long receiver hold-off early in the random part
    initial begin
        repeat (20000) @(posedge i_clk);
        hold_res = 1;
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected result", 64'(res_if.data.status), 64'd0);
            end else begin
                want = pending_res.pop_front();
                if (res_if.data.status !== want.status)
                    report_mismatch("status", 64'(res_if.data.status), 64'(want.status));
                if (res_if.data.removed_valid !== want.removed_valid)
                    report_mismatch("removed_valid", 64'(res_if.data.removed_valid),
                                    64'(want.removed_valid));
                if (res_if.data.removed_lock !== want.removed_lock)
                    report_mismatch("removed_lock", res_if.data.removed_lock,
                                    want.removed_lock);
                if (res_if.data.conflict_owner !== want.conflict_owner)
                    report_mismatch("conflict_owner", res_if.data.conflict_owner,
                                    want.conflict_owner);
                if (res_if.data.conflict_offset !== want.conflict_offset)
                    report_mismatch("conflict_offset", res_if.data.conflict_offset,
                                    want.conflict_offset);
                if (res_if.data.conflict_length !== want.conflict_length)
                    report_mismatch("conflict_length", res_if.data.conflict_length,
                                    want.conflict_length);
                if (res_if.data.conflict_pid !== want.conflict_pid)
                    report_mismatch("conflict_pid", 64'(res_if.data.conflict_pid),
                                    64'(want.conflict_pid));
                if (res_if.data.conflict_mode !== want.conflict_mode)
                    report_mismatch("conflict_mode", 64'(res_if.data.conflict_mode),
                                    64'(want.conflict_mode));
                if (res_if.data.held_origin !== want.held_origin)
                    report_mismatch("held_origin", 64'(res_if.data.held_origin),
                                    64'(want.held_origin));
                if (res_if.data.last !== want.last)
                    report_mismatch("last", 64'(res_if.data.last), 64'(want.last));
            end
        end
    end

    initial begin
        wait (send_done);
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (4 * NS + 20) @(posedge i_clk);
        if (err_count == 0 && pending_res.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
